// ===== rtl/cave_automaton_smoothing_core_macros.svh =====
// Assertion shorthands shared by the smoothing core RTL.
`ifndef CAVE_AUTOMATON_SMOOTHING_CORE_MACROS_SVH
`define CAVE_AUTOMATON_SMOOTHING_CORE_MACROS_SVH

// Same-cycle implication, idle during reset.
`define CAS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, idle during reset.
`define CAS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cas_pkg.sv =====
`default_nettype none

package cas_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int BUFFER_ROWS = 4;
	localparam int WIN         = BUFFER_ROWS + 1;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT + 4);
	localparam int EXT_W   = ROW_W + 2;
	localparam int PHASE_W = $clog2(BUFFER_ROWS);

	localparam int SIZE_W = 9;
	localparam int NEAR_W = 4;
	localparam int FAR_W  = 6;
	localparam int CFG_W  = 9;
	localparam int IDX_W  = 2;

	localparam int R1_W = 4;
	localparam int R2_W = 5;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = 9'd64;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 9'd64;
	localparam logic [NEAR_W-1:0] NEAR_RST   = 4'd5;
	localparam logic [FAR_W-1:0]  FAR_RST    = 6'h3F;

	typedef enum logic [IDX_W-1:0] {
		REG_GRID_WIDTH,
		REG_GRID_HEIGHT,
		REG_NEAR_CUTOFF,
		REG_FAR_CUTOFF
	} cas_reg_t;

	typedef struct packed {
		logic               in_grid;
		logic               tile;
		logic [PHASE_W-1:0] phase;
		logic               emit;
		logic               force_wall;
		logic               last;
		logic [WIN-1:0]     col_ok;
		logic [WIN-1:0]     row_ok;
	} cas_ctl_t;

	function automatic logic [SIZE_W-1:0] clamp_size(
		input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] hi
	);
		logic [SIZE_W-1:0] res;
		res = v;
		if (v < SIZE_W'(3)) begin
			res = SIZE_W'(3);
		end else if (v > hi) begin
			res = hi;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/cas_in_if.sv =====
`default_nettype none

interface cas_in_if;
	logic valid;
	logic ready;
	logic action;
	logic tile_is_wall;

	modport source (output valid, output action, output tile_is_wall, input ready);
	modport sink (input valid, input action, input tile_is_wall, output ready);
endinterface

`default_nettype wire

// ===== rtl/cas_out_if.sv =====
`default_nettype none

interface cas_out_if;
	logic valid;
	logic ready;
	logic result_is_wall;
	logic frame_last;

	modport source (output valid, output result_is_wall, output frame_last, input ready);
	modport sink (input valid, input result_is_wall, input frame_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/cas_line_buf.sv =====
`default_nettype none
`include "cave_automaton_smoothing_core_macros.svh"

module cas_line_buf import cas_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   rd_en,
	input  wire logic [COL_W-1:0]       rd_addr,
	input  wire logic                   wr_en,
	input  wire logic [PHASE_W-1:0]     phase,
	input  wire logic                   tile,
	output logic      [BUFFER_ROWS-1:0] col_lo
);

	logic [BUFFER_ROWS-1:0] mem [MAX_WIDTH];
	logic [BUFFER_ROWS-1:0] rd_s1;
	logic [BUFFER_ROWS-1:0] wr_data;
	logic [COL_W-1:0]       addr_s1;
	logic [COL_W-1:0]       wr_addr_q;
	logic                   wr_last_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1   <= mem[rd_addr];
			addr_s1 <= rd_addr;
		end
		if (wr_en) begin
			mem[addr_s1] <= wr_data;
		end
		wr_addr_q <= addr_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_last_q <= 1'b0;
		end else begin
			wr_last_q <= wr_en;
		end
	end

	// oldest row lands in bit 0
	always_comb begin
		wr_data = rd_s1;
		wr_data[phase] = tile;
		for (int k = 0; k < BUFFER_ROWS; k++) begin
			col_lo[k] = rd_s1[PHASE_W'(phase + PHASE_W'(k))];
		end
	end

	`CAS_ASSERT_IMPL(lb_rmw_no_overlap, wr_en && wr_last_q, addr_s1 != wr_addr_q,
		"line buffer written at the same column on consecutive cycles")

endmodule

`default_nettype wire

// ===== rtl/cas_smooth.sv =====
`default_nettype none

module cas_smooth import cas_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   shift_en,
	input  wire cas_ctl_t               ctl,
	input  wire logic [BUFFER_ROWS-1:0] col_lo,
	input  wire logic [NEAR_W-1:0]      near,
	input  wire logic [FAR_W-1:0]       far,
	output logic                        wall
);

	logic [WIN*WIN-1:0] win_q;
	logic [WIN*WIN-1:0] win_nxt;
	logic [WIN-1:0]     col_full;
	logic [R1_W-1:0]    r1;
	logic [R2_W-1:0]    r2;
	logic               near_hit;
	logic               far_hit;

	assign col_full = {ctl.tile & ctl.in_grid, col_lo};

	always_comb begin
		for (int i = 0; i < WIN; i++) begin
			for (int p = 0; p < WIN - 1; p++) begin
				win_nxt[i*WIN + p] = win_q[i*WIN + p + 1];
			end
			win_nxt[i*WIN + WIN - 1] = col_full[i];
		end
	end

	always_comb begin
		logic hit;
		logic corner;
		r1 = '0;
		r2 = '0;
		for (int i = 0; i < WIN; i++) begin
			for (int p = 0; p < WIN; p++) begin
				hit    = win_nxt[i*WIN + p] & ctl.row_ok[i] & ctl.col_ok[p];
				corner = (i == 0 || i == WIN - 1) && (p == 0 || p == WIN - 1);
				if (hit && !corner) begin
					r2 = r2 + R2_W'(1);
				end
				if (hit && i >= 1 && i <= WIN - 2 && p >= 1 && p <= WIN - 2) begin
					r1 = r1 + R1_W'(1);
				end
			end
		end
	end

	assign near_hit = r1 >= near;
	assign far_hit  = $signed((FAR_W+1)'(r2)) <= $signed({far[FAR_W-1], far});
	assign wall     = ctl.force_wall || near_hit || far_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (shift_en) begin
			win_q <= win_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cave_automaton_smoothing_core.sv =====
// Smooths a wall/floor grid streamed in raster order with the 4-5 cave rule, one tile per
// clock unless the output stalls. Each tile beat enters a line-buffer memory that is read,
// updated and written back, one column a cycle, and a 5x5 window register decides the tile
// two rows and two columns back; a further output register, after the stage register that
// holds the completing tile, gives its beat. Results trail the input by 2*grid_width+2
// tiles, so the tail of each grid is pushed out with drain beats (action = 1); a drain beat
// sent while tiles are still expected is taken and dropped. frame_last marks the final tile,
// after which the next beat starts a new grid. Sizes clamp to 3..256. The line buffer needs
// no clearing after reset. Write configuration only while no grid is in flight.
`default_nettype none
`include "cave_automaton_smoothing_core_macros.svh"

module cave_automaton_smoothing_core import cas_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	cas_in_if.sink                tiles,
	cas_out_if.source             smoothed,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [NEAR_W-1:0] near_q;
	logic [FAR_W-1:0]  far_q;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_d;
	logic [ROW_W-1:0]  row_d;

	logic [SIZE_W-1:0] w;
	logic [SIZE_W-1:0] h;
	logic [EXT_W-1:0]  w_ext;
	logic [EXT_W-1:0]  h_ext;
	logic [COL_W-1:0]  c_cur;
	logic [EXT_W-1:0]  c_ext;
	logic [EXT_W-1:0]  r_ext;
	logic [EXT_W-1:0]  c_inc;
	logic [EXT_W-1:0]  xe;
	logic [EXT_W-1:0]  y4;

	logic     adv;
	logic     accept;
	logic     in_grid;
	logic     drop;
	logic     is_c0;
	logic     is_c1;
	logic     last0;
	cas_ctl_t ctl0;

	logic     valid_s1;
	cas_ctl_t ctl_s1;
	logic     out_valid_q;
	logic     out_wall_q;
	logic     out_last_q;

	logic [BUFFER_ROWS-1:0] col_lo;
	logic                   wall;

	assign w     = clamp_size(width_q, SIZE_W'(MAX_WIDTH));
	assign h     = clamp_size(height_q, SIZE_W'(MAX_HEIGHT));
	assign w_ext = EXT_W'(w);
	assign h_ext = EXT_W'(h);

	assign adv          = !out_valid_q || smoothed.ready;
	assign tiles.ready  = adv;
	assign accept       = tiles.valid && adv;

	// wrap a stale position left by a size change
	always_comb begin
		c_cur = col_q;
		r_ext = EXT_W'(row_q);
		if (EXT_W'(col_q) >= w_ext) begin
			c_cur = '0;
			r_ext = EXT_W'(row_q) + EXT_W'(1);
		end
		if (r_ext > h_ext + EXT_W'(2)) begin
			c_cur = '0;
			r_ext = '0;
		end
	end

	assign c_ext   = EXT_W'(c_cur);
	assign c_inc   = c_ext + EXT_W'(1);
	assign in_grid = r_ext < h_ext;
	assign drop    = tiles.action && in_grid;
	assign is_c0   = c_cur == '0;
	assign is_c1   = c_cur == COL_W'(1);
	assign last0   = is_c1 && r_ext == h_ext + EXT_W'(2);

	// column zero finishes the previous row's last inner cell on a shifted window
	assign xe = is_c0 ? w_ext : c_ext;
	assign y4 = is_c0 ? r_ext - EXT_W'(1) : r_ext;

	always_comb begin
		ctl0.in_grid    = in_grid;
		ctl0.tile       = tiles.tile_is_wall;
		ctl0.phase      = r_ext[PHASE_W-1:0];
		ctl0.emit       = ((is_c0 || is_c1) && r_ext >= EXT_W'(3))
			|| (c_ext >= EXT_W'(2) && r_ext >= EXT_W'(2) && r_ext <= h_ext + EXT_W'(1));
		ctl0.force_wall = is_c1 || (!is_c0 && c_ext == EXT_W'(2))
			|| y4 == EXT_W'(2) || y4 == h_ext + EXT_W'(1);
		ctl0.last       = last0;
		for (int k = 0; k < WIN; k++) begin
			ctl0.col_ok[k] = (xe + EXT_W'(k) >= EXT_W'(WIN - 1))
				&& (xe + EXT_W'(k) < w_ext + EXT_W'(WIN - 1));
			ctl0.row_ok[k] = (y4 + EXT_W'(k) >= EXT_W'(WIN - 1))
				&& (y4 + EXT_W'(k) < h_ext + EXT_W'(WIN - 1));
		end
	end

	always_comb begin
		if (drop) begin
			col_d = c_cur;
			row_d = r_ext[ROW_W-1:0];
		end else if (last0) begin
			col_d = '0;
			row_d = '0;
		end else if (c_inc >= w_ext) begin
			col_d = '0;
			row_d = ROW_W'(r_ext + EXT_W'(1));
		end else begin
			col_d = c_inc[COL_W-1:0];
			row_d = r_ext[ROW_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			near_q   <= NEAR_RST;
			far_q    <= FAR_RST;
		end else if (cfg_we) begin
			unique case (cas_reg_t'(cfg_index))
				REG_GRID_WIDTH:  width_q  <= cfg_data[SIZE_W-1:0];
				REG_GRID_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				REG_NEAR_CUTOFF: near_q   <= cfg_data[NEAR_W-1:0];
				REG_FAR_CUTOFF:  far_q    <= cfg_data[FAR_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				col_q <= col_d;
				row_q <= row_d;
			end
			if (adv) begin
				valid_s1    <= accept && !drop;
				out_valid_q <= valid_s1 && ctl_s1.emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1     <= ctl0;
			out_wall_q <= wall;
			out_last_q <= ctl_s1.last;
		end
	end

	cas_line_buf u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && !drop),
		.rd_addr (c_cur),
		.wr_en   (adv && valid_s1 && ctl_s1.in_grid),
		.phase   (ctl_s1.phase),
		.tile    (ctl_s1.tile),
		.col_lo  (col_lo)
	);

	cas_smooth u_smooth (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (adv && valid_s1),
		.ctl      (ctl_s1),
		.col_lo   (col_lo),
		.near     (near_q),
		.far      (far_q),
		.wall     (wall)
	);

	assign smoothed.valid          = out_valid_q;
	assign smoothed.result_is_wall = out_wall_q;
	assign smoothed.frame_last     = out_last_q;

	`CAS_ASSERT_IMPL(last_beat_is_wall, smoothed.valid && smoothed.frame_last,
		smoothed.result_is_wall, "final tile of a grid left as floor")
	`CAS_ASSERT_IMPL(last_in_tail, accept && !drop && last0, !in_grid,
		"grid closed while tiles still expected")
	`CAS_ASSERT_NEXT(last_rewinds, accept && !drop && last0, col_q == '0 && row_q == '0,
		"position not rewound after the final tile")

endmodule

`default_nettype wire
